[rtl/tgpbv_pkg.sv]
// tgpbv_pkg: shared widths, constants and word types for the triangle
// quadrature basis core; no dependencies, imported by all rtl modules
package tgpbv_pkg;

   localparam int COORD_BITS    = 32;
   localparam int FRAC_BITS_DEF = 16;
   localparam int HW            = COORD_BITS - 1;   // half extent width
   localparam int MAG_W         = COORD_BITS + 5;   // |30 * offset| width
   localparam int DW            = COORD_BITS + 4;   // 30 * half extent width
   localparam int QB            = 22;               // quotient bits incl. round bit
   localparam int BASIS_W       = 20;
   localparam int DIV_LAT       = QB + 2;

   localparam logic [QB-1:0] BASIS_MAX     = QB'(524287);
   localparam logic [QB-1:0] BASIS_MIN_MAG = QB'(524288);

   // point slot codes, seven points per triangle
   localparam logic [2:0] FIRST_RULE1_K = 3'd3;
   localparam logic [2:0] LAST_K        = 3'd6;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] x_vertex_a;
      logic signed [COORD_BITS-1:0] y_vertex_a;
      logic signed [COORD_BITS-1:0] x_vertex_b;
      logic signed [COORD_BITS-1:0] y_vertex_b;
      logic signed [COORD_BITS-1:0] x_vertex_c;
      logic signed [COORD_BITS-1:0] y_vertex_c;
   } req_word_type;

   typedef struct packed {
      logic                      rule_kind;
      logic [1:0]                point_index;
      logic signed [BASIS_W-1:0] basis_x;
      logic signed [BASIS_W-1:0] basis_y;
      logic [31:0]               half_extent_x;
      logic [31:0]               half_extent_y;
      logic                      degenerate;
      logic                      last_point;
   } rsp_word_type;

   // side data that rides next to the dividers
   typedef struct packed {
      logic        rule_kind;
      logic [1:0]  point_index;
      logic [31:0] half_extent_x;
      logic [31:0] half_extent_y;
      logic        degenerate;
      logic        last_point;
   } tag_type;

   // one divider operand set
   typedef struct packed {
      logic             neg;
      logic             zero;
      logic [MAG_W-1:0] mag;
      logic [DW-1:0]    den;
   } axis_type;

   typedef struct packed {
      tag_type  tag;
      axis_type ax_x;
      axis_type ax_y;
   } issue_type;

endpackage

[rtl/triangle_gauss_point_basis_values_core.sv]
// triangle_gauss_point_basis_values_core: top level; sequencer, two dividers
// and the aligned tag line; uses tgpbv_pkg, tgpbv_issue, tgpbv_div
//
//   channel | dir | ports                          | word
//   req     | in  | req_valid, req_stall, req_word | one triangle
//   rsp     | out | rsp_valid, rsp_stall, rsp_word | one quadrature point
//
// each triangle gives seven words, one per advancing cycle; the sequencer feeds
// one point per cycle unless the output stalls and takes the next triangle
// as the last point slot issues; from accept a word passes the holding register,
// 3 operand stages and 24 divider stages
// reset clears only the valid bits and the point counter
// a stalled word at the output freezes the whole pipeline in place
module triangle_gauss_point_basis_values_core #(
   parameter int FRAC_BITS = tgpbv_pkg::FRAC_BITS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  tgpbv_pkg::req_word_type req_word,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output tgpbv_pkg::rsp_word_type rsp_word
);
   import tgpbv_pkg::*;

   logic      adv;
   logic      iss_vld;
   issue_type iss_slot;
   logic signed [BASIS_W-1:0] bx, by;

   logic    vld_ff [0:DIV_LAT-1];
   tag_type tag_ff [0:DIV_LAT-1];

   // global advance unless the output word is held
   assign adv = !(rsp_valid && rsp_stall);

   tgpbv_issue u_issue (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .req_valid (req_valid),
      .req_word  (req_word),
      .req_stall (req_stall),
      .out_vld   (iss_vld),
      .out_slot  (iss_slot)
   );

   tgpbv_div #(.FRAC_BITS(FRAC_BITS)) u_div_x (
      .clock     (clock),
      .adv       (adv),
      .in_ax     (iss_slot.ax_x),
      .out_basis (bx)
   );

   tgpbv_div #(.FRAC_BITS(FRAC_BITS)) u_div_y (
      .clock     (clock),
      .adv       (adv),
      .in_ax     (iss_slot.ax_y),
      .out_basis (by)
   );

   // tag and valid line matched to divider latency
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DIV_LAT; i++) begin
            vld_ff[i] <= 1'b0;
         end
      end else if (adv) begin
         vld_ff[0] <= iss_vld;
         for (int i = 1; i < DIV_LAT; i++) begin
            vld_ff[i] <= vld_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         tag_ff[0] <= iss_slot.tag;
         for (int i = 1; i < DIV_LAT; i++) begin
            tag_ff[i] <= tag_ff[i-1];
         end
      end
   end

   // output word
   assign rsp_valid              = vld_ff[DIV_LAT-1];
   assign rsp_word.rule_kind     = tag_ff[DIV_LAT-1].rule_kind;
   assign rsp_word.point_index   = tag_ff[DIV_LAT-1].point_index;
   assign rsp_word.basis_x       = bx;
   assign rsp_word.basis_y       = by;
   assign rsp_word.half_extent_x = tag_ff[DIV_LAT-1].half_extent_x;
   assign rsp_word.half_extent_y = tag_ff[DIV_LAT-1].half_extent_y;
   assign rsp_word.degenerate    = tag_ff[DIV_LAT-1].degenerate;
   assign rsp_word.last_point    = tag_ff[DIV_LAT-1].last_point;

   // midpoint rule has only three points
   a_rule0_index: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_word.rule_kind |-> rsp_word.point_index != 2'd3)
      else $error("rule 0 word with point index 3");

   // last word is the fourth point of the four-point rule
   a_last_slot: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.last_point |->
      rsp_word.rule_kind && rsp_word.point_index == 2'd3)
      else $error("last word on wrong slot");

   // centroid point sits at the origin
   a_centroid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.rule_kind && rsp_word.point_index == 2'd0 |->
      rsp_word.basis_x == '0 && rsp_word.basis_y == '0)
      else $error("centroid basis not zero");

   // zero extent forces zero quotient and the flag
   a_zero_ext: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_word.half_extent_x == '0) |->
      rsp_word.degenerate && rsp_word.basis_x == '0)
      else $error("zero x extent not flagged");

endmodule

[rtl/tgpbv_issue.sv]
// tgpbv_issue: triangle holding register, seven-point sequencer and the three
// operand stages (vertex copy, offsets/half extents, operands); uses tgpbv_pkg
module tgpbv_issue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  adv,
   input  logic                  req_valid,
   input  tgpbv_pkg::req_word_type req_word,
   output logic                  req_stall,
   output logic                  out_vld,
   output tgpbv_pkg::issue_type  out_slot
);
   import tgpbv_pkg::*;

   localparam int C = COORD_BITS;

   // 30 * (point - centroid) up to the factor 5 or 4
   function automatic logic signed [C+2:0] offs(input logic [2:0] k,
         input logic signed [C-1:0] a, input logic signed [C-1:0] b,
         input logic signed [C-1:0] c);
      logic signed [C+2:0] ea, eb, ec, t;
      ea = {{3{a[C-1]}}, a};
      eb = {{3{b[C-1]}}, b};
      ec = {{3{c[C-1]}}, c};
      case (k)
         3'd0:    t = ea + ec - (eb <<< 1);
         3'd1:    t = ea + eb - (ec <<< 1);
         3'd2:    t = eb + ec - (ea <<< 1);
         3'd4:    t = (ea <<< 1) - eb - ec;
         3'd5:    t = (eb <<< 1) - ea - ec;
         3'd6:    t = (ec <<< 1) - ea - eb;
         default: t = '0;
      endcase
      return t;
   endfunction

   // half of bounding box span, truncated
   function automatic logic [HW-1:0] half(input logic signed [C-1:0] p,
         input logic signed [C-1:0] q, input logic signed [C-1:0] s);
      logic signed [C-1:0] mx, mn;
      logic [C:0] diff;
      mx = p;
      mn = p;
      if (q > mx) mx = q;
      if (s > mx) mx = s;
      if (q < mn) mn = q;
      if (s < mn) mn = s;
      diff = {mx[C-1], mx} - {mn[C-1], mn};
      return diff[C-1:1];
   endfunction

   // divider operands from an offset and a half extent
   function automatic axis_type mk_axis(input logic rule0,
         input logic signed [C+2:0] t, input logic [HW-1:0] h);
      logic signed [C+5:0] e5, num, mag_full;
      axis_type ax;
      e5       = {{3{t[C+2]}}, t};
      num      = rule0 ? (e5 <<< 2) + e5 : (e5 <<< 2);
      mag_full = num[C+5] ? -num : num;
      ax.neg   = num[C+5];
      ax.zero  = (h == '0);
      ax.mag   = mag_full[MAG_W-1:0];
      ax.den   = (DW'(h) << 5) - (DW'(h) << 1);
      return ax;
   endfunction

   logic         tri_vld_ff;
   req_word_type tri_ff;
   logic [2:0]   k_ff;
   logic         last_k;
   logic         accept;

   logic         s1_vld_ff;
   req_word_type s1_ff;
   logic [2:0]   s1_k_ff;

   logic                s2_vld_ff;
   logic [2:0]          s2_k_ff;
   logic signed [C+2:0] s2_tx_ff, s2_ty_ff;
   logic [HW-1:0]       s2_hx_ff, s2_hy_ff;

   logic      s3_vld_ff;
   issue_type s3_ff;
   issue_type s3_in;

   // sequencer: one point slot per advancing cycle
   assign last_k    = (k_ff == LAST_K);
   assign req_stall = tri_vld_ff && !(adv && last_k);
   assign accept    = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         tri_vld_ff <= 1'b0;
         k_ff       <= '0;
      end else begin
         if (accept) begin
            tri_vld_ff <= 1'b1;
         end else if (adv && tri_vld_ff && last_k) begin
            tri_vld_ff <= 1'b0;
         end
         if (adv && tri_vld_ff) begin
            k_ff <= last_k ? 3'd0 : k_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         tri_ff <= req_word;
      end
   end

   // stage valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
      end else if (adv) begin
         s1_vld_ff <= tri_vld_ff;
         s2_vld_ff <= s1_vld_ff;
         s3_vld_ff <= s2_vld_ff;
      end
   end

   // stage 3 operand and tag build
   always_comb begin
      s3_in.tag.rule_kind     = (s2_k_ff >= FIRST_RULE1_K);
      s3_in.tag.point_index   = (s2_k_ff >= FIRST_RULE1_K) ?
                                2'(s2_k_ff - FIRST_RULE1_K) : s2_k_ff[1:0];
      s3_in.tag.half_extent_x = 32'(s2_hx_ff);
      s3_in.tag.half_extent_y = 32'(s2_hy_ff);
      s3_in.tag.degenerate    = (s2_hx_ff == '0) || (s2_hy_ff == '0);
      s3_in.tag.last_point    = (s2_k_ff == LAST_K);
      s3_in.ax_x = mk_axis(s2_k_ff < FIRST_RULE1_K, s2_tx_ff, s2_hx_ff);
      s3_in.ax_y = mk_axis(s2_k_ff < FIRST_RULE1_K, s2_ty_ff, s2_hy_ff);
   end

   // stage payload
   always_ff @(posedge clock) begin
      if (adv) begin
         s1_ff    <= tri_ff;
         s1_k_ff  <= k_ff;
         s2_k_ff  <= s1_k_ff;
         s2_tx_ff <= offs(s1_k_ff, s1_ff.x_vertex_a, s1_ff.x_vertex_b, s1_ff.x_vertex_c);
         s2_ty_ff <= offs(s1_k_ff, s1_ff.y_vertex_a, s1_ff.y_vertex_b, s1_ff.y_vertex_c);
         s2_hx_ff <= half(s1_ff.x_vertex_a, s1_ff.x_vertex_b, s1_ff.x_vertex_c);
         s2_hy_ff <= half(s1_ff.y_vertex_a, s1_ff.y_vertex_b, s1_ff.y_vertex_c);
         s3_ff    <= s3_in;
      end
   end

   assign out_vld  = s3_vld_ff;
   assign out_slot = s3_ff;

endmodule

[rtl/tgpbv_div.sv]
// tgpbv_div: pipelined restoring divider, one quotient bit per stage, with
// round half away from zero and saturation to the basis range; uses tgpbv_pkg
module tgpbv_div #(
   parameter int FRAC_BITS = tgpbv_pkg::FRAC_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 adv,
   input  tgpbv_pkg::axis_type                  in_ax,
   output logic signed [tgpbv_pkg::BASIS_W-1:0] out_basis
);
   import tgpbv_pkg::*;

   localparam int NW = MAG_W + FRAC_BITS + 1;
   localparam int DQ = DW + QB;
   localparam int WW = ((NW > DQ) ? NW : DQ) + 1;

   typedef struct packed {
      logic          neg;
      logic          zero;
      logic          ovf;
      logic [DW-1:0] den;
      logic [WW-1:0] rem;
      logic [QB-1:0] quo;
   } dstage_type;

   dstage_type st_ff [0:QB];
   dstage_type st0_in;
   logic signed [BASIS_W-1:0] out_ff;
   logic signed [BASIS_W-1:0] out_in;
   logic [QB:0]   q_inc;
   logic [QB-1:0] q_rnd;

   // prep: scale numerator, check quotient overflow
   always_comb begin
      st0_in.neg  = in_ax.neg;
      st0_in.zero = in_ax.zero;
      st0_in.den  = in_ax.den;
      st0_in.rem  = WW'(in_ax.mag) << (FRAC_BITS + 1);
      st0_in.quo  = '0;
      st0_in.ovf  = (st0_in.rem >= (WW'(in_ax.den) << QB));
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         st_ff[0] <= st0_in;
      end
   end

   // one compare and subtract per stage
   for (genvar j = 0; j < QB; j++) begin : g_step
      localparam int BIT = QB - 1 - j;
      logic [WW-1:0] dsh;
      logic          ge;
      dstage_type    nxt_in;
      always_comb begin
         dsh         = WW'(st_ff[j].den) << BIT;
         ge          = (st_ff[j].rem >= dsh);
         nxt_in      = st_ff[j];
         nxt_in.rem  = ge ? st_ff[j].rem - dsh : st_ff[j].rem;
         nxt_in.quo[BIT] = ge;
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            st_ff[j+1] <= nxt_in;
         end
      end
   end

   // round, apply sign and saturate
   always_comb begin
      q_inc = {1'b0, st_ff[QB].quo} + (QB+1)'(1);
      q_rnd = q_inc[QB:1];
      if (st_ff[QB].zero) begin
         out_in = '0;
      end else if (st_ff[QB].neg) begin
         if (st_ff[QB].ovf || (q_rnd > BASIS_MIN_MAG)) begin
            out_in = BASIS_W'(-(QB+1)'(BASIS_MIN_MAG));
         end else begin
            out_in = BASIS_W'(-q_rnd);
         end
      end else begin
         if (st_ff[QB].ovf || (q_rnd > BASIS_MAX)) begin
            out_in = BASIS_W'(BASIS_MAX);
         end else begin
            out_in = BASIS_W'(q_rnd);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         out_ff <= out_in;
      end
   end

   assign out_basis = out_ff;

endmodule
